// ===== rtl/ebrm_pkg.sv =====
`timescale 1ns / 1ps
package ebrm_pkg;

	// operation codes
	typedef enum logic [5:0] {
		OP_HWR = 6'd0, OP_HRD = 6'd1, OP_INC = 6'd2, OP_DEC = 6'd3, OP_IRX = 6'd4,
		OP_GLO = 6'd5, OP_PLO = 6'd6, OP_GHI = 6'd7, OP_PHI = 6'd8, OP_LDN = 6'd9,
		OP_LDA = 6'd10, OP_LDX = 6'd11, OP_LDXA = 6'd12, OP_LDI = 6'd13, OP_STR = 6'd14,
		OP_STXD = 6'd15, OP_OR = 6'd16, OP_ORI = 6'd17, OP_XOR = 6'd18, OP_XRI = 6'd19,
		OP_AND = 6'd20, OP_ANI = 6'd21, OP_SHR = 6'd22, OP_SHRC = 6'd23, OP_SHL = 6'd24,
		OP_SHLC = 6'd25, OP_ADD = 6'd26, OP_ADI = 6'd27, OP_ADC = 6'd28, OP_ADCI = 6'd29,
		OP_SD = 6'd30, OP_SDI = 6'd31, OP_SDB = 6'd32, OP_SDBI = 6'd33, OP_SM = 6'd34,
		OP_SMI = 6'd35, OP_SMB = 6'd36, OP_SMBI = 6'd37, OP_BR = 6'd38, OP_LBR = 6'd39,
		OP_LSK = 6'd40, OP_SEP = 6'd41, OP_SEX = 6'd42, OP_SEQ = 6'd43, OP_REQ = 6'd44,
		OP_INT = 6'd45, OP_SAV = 6'd46, OP_NOP = 6'd47
	} op_t;

	// condition codes
	localparam logic [4:0] C_ALW = 5'd0, C_NEV = 5'd1, C_DZ = 5'd2, C_DNZ = 5'd3;
	localparam logic [4:0] C_DF = 5'd4, C_NDF = 5'd5, C_Q = 5'd6, C_NQ = 5'd7;
	localparam logic [4:0] C_EF1 = 5'd8, C_NEF1 = 5'd9, C_EF2 = 5'd10, C_NEF2 = 5'd11;
	localparam logic [4:0] C_EF3 = 5'd12, C_NEF3 = 5'd13, C_EF4 = 5'd14, C_NEF4 = 5'd15;
	localparam logic [4:0] C_IE = 5'd16;

	localparam logic [15:0] HI_MASK = 16'hFF00;
	localparam logic [15:0] LO_MASK = 16'h00FF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_LONG,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [5:0] mode;
		logic [3:0] reg_n;
		logic [4:0] condition;
		logic [3:0] ef_lines;
		logic [15:0] host_address;
		logic [7:0] host_data;
	} item_t;

	typedef struct packed {
		logic [7:0] d_value;
		logic carry_out;
		logic q_out;
		logic [3:0] p_index;
		logic [3:0] x_index;
		logic [15:0] reg_value;
		logic [7:0] mem_data;
	} result_t;

endpackage

// ===== rtl/eight_bit_register_machine_execute_core.sv =====
`timescale 1ns / 1ps
// Execute core of an 8-bit accumulator machine with sixteen 16-bit pointer
// registers and an internal byte memory.
// Channels: s_axis carries one decoded instruction per transfer, m_axis
// returns one result per instruction with D, DF, Q, P, X, R(N) and the host
// read byte. Host write and host read modes load and inspect the memory.
// Flow: the instruction is registered; then the run state reads the register
// file for R(N), R(P), R(X) and presents a memory address; next the memory
// data returns and the write-back happens. A taken long branch reads a
// second byte in the long state between run and done. This sequence is
// set by the single read port of the byte memory and the register-file
// read.
// The result sits in an output register; a new item is taken in the cycle
// the previous one finishes, so items can follow back to back.
// Reset clears the registers, flags and control; IE resets to one. The
// byte memory is not cleared. If the receiver stalls, the finished result
// holds and the core stops after at most one further item, which waits
// in its final cycle until the output slot frees up.
module eight_bit_register_machine_execute_core
	import ebrm_pkg::*;
#(
	parameter int MEMORY_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[5:0], reg_n[9:6], condition[14:10], ef_lines[18:15],
	// host_address[34:19], host_data[42:35], zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// d_value[7:0], carry_out[8], q_out[9], p_index[13:10], x_index[17:14],
	// reg_value[33:18], mem_data[41:34], zero pad
	output logic [47:0] m_axis_tdata
);

	localparam int AW = $clog2(MEMORY_DEPTH);

	state_t state_q, state_nx;
	item_t it_s1;
	logic [15:0] rf_q [16];
	logic [7:0] mem [MEMORY_DEPTH];
	logic [7:0] mrd_q;
	logic [7:0] d_q;
	logic df_q, q_q, ie_q;
	logic [3:0] p_q, x_q;
	logic [7:0] t_q;
	logic [15:0] rp_s2;
	logic [7:0] hi_s2;
	logic out_v_q;
	result_t out_q;

	logic take, fin;
	logic [15:0] rn, rp, rx, maddr;
	logic mwe;
	logic [7:0] mwd;
	logic cond_ok;
	logic [AW-1:0] ra;

	assign s_axis_tready = (state_q == ST_IDLE) || fin;
	assign take = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {6'd0, out_q.mem_data, out_q.reg_value, out_q.x_index,
		out_q.p_index, out_q.q_out, out_q.carry_out, out_q.d_value};

	assign rn = rf_q[it_s1.reg_n];
	assign rp = rf_q[p_q];
	assign rx = rf_q[x_q];

	// condition test
	always_comb begin
		case (it_s1.condition)
			C_ALW: cond_ok = 1'b1;
			C_NEV: cond_ok = 1'b0;
			C_DZ: cond_ok = (d_q == 8'd0);
			C_DNZ: cond_ok = (d_q != 8'd0);
			C_DF: cond_ok = df_q;
			C_NDF: cond_ok = !df_q;
			C_Q: cond_ok = q_q;
			C_NQ: cond_ok = !q_q;
			C_EF1: cond_ok = it_s1.ef_lines[0];
			C_NEF1: cond_ok = !it_s1.ef_lines[0];
			C_EF2: cond_ok = it_s1.ef_lines[1];
			C_NEF2: cond_ok = !it_s1.ef_lines[1];
			C_EF3: cond_ok = it_s1.ef_lines[2];
			C_NEF3: cond_ok = !it_s1.ef_lines[2];
			C_EF4: cond_ok = it_s1.ef_lines[3];
			C_NEF4: cond_ok = !it_s1.ef_lines[3];
			C_IE: cond_ok = ie_q;
			default: cond_ok = 1'b0;
		endcase
	end

	// memory address in the run and long states, write in the run state
	always_comb begin
		maddr = rx;
		mwe = 1'b0;
		mwd = d_q;
		case (op_t'(it_s1.mode))
			OP_HWR: begin maddr = it_s1.host_address; mwe = 1'b1; mwd = it_s1.host_data; end
			OP_HRD: maddr = it_s1.host_address;
			OP_LDN, OP_LDA, OP_STR: maddr = rn;
			OP_LDI, OP_ORI, OP_XRI, OP_ANI, OP_ADI, OP_ADCI, OP_SDI, OP_SDBI,
			OP_SMI, OP_SMBI, OP_BR, OP_LBR: maddr = rp;
			default: maddr = rx;
		endcase
		if (state_q == ST_LONG) maddr = rp_s2 + 16'd1;
		if (state_q == ST_RUN) begin
			if (op_t'(it_s1.mode) == OP_STR || op_t'(it_s1.mode) == OP_STXD) mwe = 1'b1;
			if (op_t'(it_s1.mode) == OP_SAV) begin mwe = 1'b1; mwd = t_q; end
		end else mwe = 1'b0;
		if (op_t'(it_s1.mode) != OP_HWR && op_t'(it_s1.mode) != OP_STR
			&& op_t'(it_s1.mode) != OP_STXD && op_t'(it_s1.mode) != OP_SAV) mwd = d_q;
	end
	assign ra = maddr[AW-1:0];

	// byte memory, one port, registered read; read data holds while done waits
	always_ff @(posedge clk) begin
		if (mwe) mem[ra] <= mwd;
		if (state_q != ST_DONE || fin) mrd_q <= mem[ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		fin = 1'b0;
		case (state_q)
			ST_IDLE: if (take) state_nx = ST_RUN;
			ST_RUN: state_nx = (op_t'(it_s1.mode) == OP_LBR && cond_ok) ? ST_LONG : ST_DONE;
			ST_LONG: state_nx = ST_DONE;
			ST_DONE: begin
				// finish only when the result slot is free
				if (!out_v_q || m_axis_tready) begin
					fin = 1'b1;
					state_nx = take ? ST_RUN : ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			it_s1.mode <= s_axis_tdata[5:0];
			it_s1.reg_n <= s_axis_tdata[9:6];
			it_s1.condition <= s_axis_tdata[14:10];
			it_s1.ef_lines <= s_axis_tdata[18:15];
			it_s1.host_address <= s_axis_tdata[34:19];
			it_s1.host_data <= s_axis_tdata[42:35];
		end
		if (state_q == ST_RUN) begin
			rp_s2 <= rp;
		end
		if (state_q == ST_LONG) hi_s2 <= mrd_q;
	end

	// execute and write back in the done cycle
	logic [8:0] alu;
	logic [7:0] opnd, d_nx;
	logic df_nx;
	logic [15:0] wv;
	logic [3:0] wi;
	logic we;
	always_comb begin
		opnd = mrd_q;
		d_nx = d_q;
		df_nx = df_q;
		alu = 9'd0;
		we = 1'b0;
		wi = it_s1.reg_n;
		wv = rn;
		case (op_t'(it_s1.mode))
			OP_INC: begin we = 1'b1; wv = rn + 16'd1; end
			OP_DEC: begin we = 1'b1; wv = rn - 16'd1; end
			OP_IRX: begin we = 1'b1; wi = x_q; wv = rx + 16'd1; end
			OP_GLO: d_nx = rn[7:0];
			OP_PLO: begin we = 1'b1; wv = (rn & HI_MASK) | {8'd0, d_q}; end
			OP_GHI: d_nx = rn[15:8];
			OP_PHI: begin we = 1'b1; wv = {d_q, 8'd0} | (rn & LO_MASK); end
			OP_LDN: d_nx = opnd;
			OP_LDA: begin d_nx = opnd; we = 1'b1; wv = rn + 16'd1; end
			OP_LDX: d_nx = opnd;
			OP_LDXA: begin d_nx = opnd; we = 1'b1; wi = x_q; wv = rx + 16'd1; end
			OP_STXD: begin we = 1'b1; wi = x_q; wv = rx - 16'd1; end
			OP_OR, OP_ORI: d_nx = d_q | opnd;
			OP_XOR, OP_XRI: d_nx = d_q ^ opnd;
			OP_AND, OP_ANI: d_nx = d_q & opnd;
			OP_LDI: d_nx = opnd;
			OP_SHR, OP_SHRC: begin
				df_nx = d_q[0];
				d_nx = {(op_t'(it_s1.mode) == OP_SHRC) & df_q, d_q[7:1]};
			end
			OP_SHL, OP_SHLC: begin
				df_nx = d_q[7];
				d_nx = {d_q[6:0], (op_t'(it_s1.mode) == OP_SHLC) & df_q};
			end
			OP_ADD, OP_ADI, OP_ADC, OP_ADCI: begin
				alu = {1'b0, d_q} + {1'b0, opnd} + {8'd0,
					(op_t'(it_s1.mode) == OP_ADC || op_t'(it_s1.mode) == OP_ADCI) & df_q};
				d_nx = alu[7:0]; df_nx = alu[8];
			end
			OP_SD, OP_SDI, OP_SDB, OP_SDBI: begin
				alu = {1'b1, opnd} - {1'b0, d_q} - {8'd0,
					(op_t'(it_s1.mode) == OP_SDB || op_t'(it_s1.mode) == OP_SDBI) & !df_q};
				d_nx = alu[7:0]; df_nx = alu[8];
			end
			OP_SM, OP_SMI, OP_SMB, OP_SMBI: begin
				alu = {1'b1, d_q} - {1'b0, opnd} - {8'd0,
					(op_t'(it_s1.mode) == OP_SMB || op_t'(it_s1.mode) == OP_SMBI) & !df_q};
				d_nx = alu[7:0]; df_nx = alu[8];
			end
			OP_BR: begin
				we = 1'b1; wi = p_q;
				wv = cond_ok ? ((rp_s2 & HI_MASK) | {8'd0, opnd}) : rp_s2 + 16'd1;
			end
			OP_LBR: begin
				we = 1'b1; wi = p_q;
				wv = cond_ok ? {hi_s2, opnd} : rp_s2 + 16'd2;
			end
			OP_LSK: begin we = cond_ok; wi = p_q; wv = rp_s2 + 16'd2; end
			default: ;
		endcase
		// immediate forms step R(P)
		case (op_t'(it_s1.mode))
			OP_LDI, OP_ORI, OP_XRI, OP_ANI, OP_ADI, OP_ADCI, OP_SDI, OP_SDBI,
			OP_SMI, OP_SMBI: begin we = 1'b1; wi = p_q; wv = rp_s2 + 16'd1; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) rf_q[i] <= 16'd0;
			d_q <= 8'd0; df_q <= 1'b0; q_q <= 1'b0; ie_q <= 1'b1;
			p_q <= 4'd0; x_q <= 4'd0; t_q <= 8'd0;
			out_v_q <= 1'b0;
		end else begin
			if (fin) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			if (fin) begin
				d_q <= d_nx;
				df_q <= df_nx;
				if (we) rf_q[wi] <= wv;
				case (op_t'(it_s1.mode))
					OP_SEP: p_q <= it_s1.reg_n;
					OP_SEX: x_q <= it_s1.reg_n;
					OP_SEQ: q_q <= 1'b1;
					OP_REQ: q_q <= 1'b0;
					OP_INT: begin
						t_q <= {x_q, p_q}; p_q <= 4'd1; x_q <= 4'd2; ie_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.d_value <= d_nx;
			out_q.carry_out <= df_nx;
			out_q.q_out <= (op_t'(it_s1.mode) == OP_SEQ) ? 1'b1 :
				(op_t'(it_s1.mode) == OP_REQ) ? 1'b0 : q_q;
			out_q.p_index <= (op_t'(it_s1.mode) == OP_SEP) ? it_s1.reg_n :
				(op_t'(it_s1.mode) == OP_INT) ? 4'd1 : p_q;
			out_q.x_index <= (op_t'(it_s1.mode) == OP_SEX) ? it_s1.reg_n :
				(op_t'(it_s1.mode) == OP_INT) ? 4'd2 : x_q;
			out_q.reg_value <= (we && wi == it_s1.reg_n) ? wv : rn;
			out_q.mem_data <= (op_t'(it_s1.mode) == OP_HRD) ? mrd_q : 8'd0;
		end
	end

`ifndef SYNTH
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_v_q || m_axis_tready)) else $error("result slot busy at finish");
	a_long_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LONG |=> state_q == ST_DONE) else $error("long branch sequence");
	a_take_state: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == ST_RUN) else $error("accepted item not run");
	a_ie_int: assert property (@(posedge clk) disable iff (!arst_n)
		fin && op_t'(it_s1.mode) == OP_INT |=> !ie_q) else $error("IE after interrupt");
`endif

endmodule
